// ----- rtl/core/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 package
// Word types, round constants, initial hash value and bit helpers shared by
// the SHA-256 digest unit.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned LEN_OFFSET  = 56;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned DIGEST_WDS  = 8;
  localparam logic [7:0]  PAD_MARK    = 8'h80;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
  } msg_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr32(x, 2) ^ rotr32(x, 13) ^ rotr32(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr32(x, 6) ^ rotr32(x, 11) ^ rotr32(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    case (idx)
      3'd0:    h = 32'h6a09e667;
      3'd1:    h = 32'hbb67ae85;
      3'd2:    h = 32'h3c6ef372;
      3'd3:    h = 32'ha54ff53a;
      3'd4:    h = 32'h510e527f;
      3'd5:    h = 32'h9b05688c;
      3'd6:    h = 32'h1f83d9ab;
      default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/sha256_message_digest_unit.sv -----
`timescale 1ns / 1ps
// Message bytes are taken one per cycle while idle; a full 64-byte block then runs
//   64 rounds and a chaining add, and msg_ready stays low until they finish.
// End of message: padding shifts in one byte per cycle up to the block end, then
//   one or two compressions, then eight digest words, one per cycle while
//   digest_ready is high; the single round unit and byte fill path set the pace.
// Reset (rst, synchronous): load the initial hash value, clear counts and flags.
// ----------------------------------------------------------------------------
// SHA-256 message digest unit
// Streaming SHA-256: packs message bytes into a block, compresses each block
// with one shared round unit, pads at end of message and returns the digest.
// ----------------------------------------------------------------------------
module sha256_message_digest_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     msg_valid,
  output logic                     msg_ready,
  input  sha256_pkg::msg_word_t    msg,
  output logic                     digest_valid,
  input  logic                     digest_ready,
  output sha256_pkg::digest_word_t digest
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,    // take message words
    ST_PAD,     // shift in padding and length bytes
    ST_ROUND,   // run the 64 compression rounds
    ST_FINAL,   // fold working variables into the chaining value
    ST_OUTPUT   // hand out the eight digest words
  } state_t;

  state_t      state;
  logic [31:0] chain [DIGEST_WDS];
  logic [31:0] wv    [DIGEST_WDS];   // a..h
  logic [31:0] win   [16];           // block bytes, then rolling schedule
  logic [6:0]  fill;                 // bytes in the block, 0..64
  logic [63:0] bit_length;
  logic [5:0]  rnd;
  logic [2:0]  out_idx;
  logic        pad_active;           // message closed, padding still to do
  logic        mark_done;            // 0x80 already placed
  logic        two_block;            // mark landed in the length field
  logic        len_done;             // length written into this block

  // Round datapath: one round of the compression per cycle.
  logic [31:0] t1, t2, w_new;
  logic [7:0]  pad_byte;
  logic [7:0]  shift_byte;
  logic        shift_en;
  logic [2:0]  len_sel;

  always_comb begin
    t1 = wv[7] + big_sigma1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6]))
       + round_const(rnd) + win[0];
    t2 = big_sigma0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
    w_new = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  end

  // Pick the next padding byte: mark, zero fill, or big-endian bit length.
  assign len_sel = fill[2:0];
  always_comb begin
    if (!mark_done) begin
      pad_byte = PAD_MARK;
    end else if (fill >= 7'(LEN_OFFSET) && !two_block) begin
      pad_byte = bit_length[{~len_sel, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign msg_ready    = (state == ST_IDLE);
  assign digest_valid = (state == ST_OUTPUT);
  assign digest.digest_word = chain[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.last_word   = (out_idx == 3'(DIGEST_WDS - 1));

  always_comb begin
    shift_en   = 1'b0;
    shift_byte = pad_byte;
    case (state)
      ST_IDLE: begin
        shift_en   = msg_valid && msg.byte_valid;
        shift_byte = msg.msg_byte;
      end
      ST_PAD:  shift_en = 1'b1;
      default: shift_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fill       <= '0;
      bit_length <= '0;
      rnd        <= '0;
      out_idx    <= '0;
      pad_active <= 1'b0;
      mark_done  <= 1'b0;
      two_block  <= 1'b0;
      len_done   <= 1'b0;
      for (int i = 0; i < DIGEST_WDS; i++) begin
        chain[i] <= init_hash(3'(i));
      end
    end else begin
      // Byte fill path: shift the block left by one byte.
      if (shift_en) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= {win[i][23:0], win[i+1][31:24]};
        end
        win[15] <= {win[15][23:0], shift_byte};
        fill    <= fill + 7'd1;
        if (fill == 7'(BLOCK_BYTES - 1)) begin
          // Block complete: load a..h and start the rounds.
          state <= ST_ROUND;
          rnd   <= '0;
          for (int i = 0; i < DIGEST_WDS; i++) begin
            wv[i] <= chain[i];
          end
        end
      end

      case (state)
        ST_IDLE: begin
          if (msg_valid) begin
            if (msg.byte_valid) begin
              bit_length <= bit_length + 64'd8;
            end
            if (msg.end_of_message) begin
              pad_active <= 1'b1;
              if (!(msg.byte_valid && fill == 7'(BLOCK_BYTES - 1))) begin
                state <= ST_PAD;
              end
            end
          end
        end
        ST_PAD: begin
          if (!mark_done) begin
            mark_done <= 1'b1;
            two_block <= (fill >= 7'(LEN_OFFSET));
          end
          if (fill == 7'(BLOCK_BYTES - 1) && mark_done && !two_block) begin
            len_done <= 1'b1;
          end
        end
        ST_ROUND: begin
          // Advance the working variables and the schedule window.
          wv[7] <= wv[6];
          wv[6] <= wv[5];
          wv[5] <= wv[4];
          wv[4] <= wv[3] + t1;
          wv[3] <= wv[2];
          wv[2] <= wv[1];
          wv[1] <= wv[0];
          wv[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w_new;
          rnd     <= rnd + 6'd1;
          if (rnd == 6'(ROUNDS - 1)) begin
            state <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          for (int i = 0; i < DIGEST_WDS; i++) begin
            chain[i] <= chain[i] + wv[i];
          end
          fill      <= '0;
          two_block <= 1'b0;
          if (len_done) begin
            state   <= ST_OUTPUT;
            out_idx <= '0;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUTPUT: begin
          if (digest_ready) begin
            if (out_idx == 3'(DIGEST_WDS - 1)) begin
              // Digest done: reload the initial hash value for the next message.
              state      <= ST_IDLE;
              fill       <= '0;
              bit_length <= '0;
              pad_active <= 1'b0;
              mark_done  <= 1'b0;
              len_done   <= 1'b0;
              for (int i = 0; i < DIGEST_WDS; i++) begin
                chain[i] <= init_hash(3'(i));
              end
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The two sides never hand off in the same cycle.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(msg_ready && digest_valid))
    else $error("input and output both open");

  // The last round always hands over to the chaining add.
  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'(ROUNDS - 1)) |=> state == ST_FINAL)
    else $error("round count overran");

  // The block never holds more than 64 bytes.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 7'(BLOCK_BYTES))
    else $error("block overfilled");

  // After the last digest word, the unit is empty and ready for a new message.
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && digest.last_word)
      |=> (msg_ready && fill == '0 && bit_length == '0))
    else $error("no clean restart after digest");

endmodule
